// ----- rtl/dlws_pkg.sv -----
// ----------------------------------------------------------------------------
// dlws_pkg
// Types, codes and shared helpers of the dictionary leaf window scanner.
// ----------------------------------------------------------------------------
package dlws_pkg;

    localparam int S_TDATA_W   = 144;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 104;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int ADDR_SPACE  = 65536;
    localparam int IDX_W       = 17;
    localparam int CODE_W      = 10;
    localparam int SIDE_W      = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] MODE_LOAD_CODE = 3'd0;
    localparam logic [2:0] MODE_LOAD_WORD = 3'd1;
    localparam logic [2:0] MODE_WINDOW    = 3'd2;
    localparam logic [2:0] MODE_ANY       = 3'd3;
    localparam logic [2:0] MODE_ALL       = 3'd4;
    localparam logic [2:0] MODE_VALUES    = 3'd5;
    localparam logic [2:0] MODE_READ      = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_SIDE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_ROW0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_COL0 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_COL1 = 3'd6;

    typedef enum logic [2:0] {
        OP_LOAD_CODE,
        OP_LOAD_WORD,
        OP_WINDOW,
        OP_ANY,
        OP_ALL,
        OP_VALUES,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_BASE,
        BK_ROW,
        BK_RSET,
        BK_SCAN,
        BK_DRAIN,
        BK_FINISH
    } bk_state_t;

    typedef struct packed {
        logic [16:0] row_stride;
        logic [3:0]  leaf_side;
        logic [31:0] range_low;
        logic [31:0] range_high;
        logic [15:0] query_row0;
        logic [15:0] query_col0;
        logic [15:0] query_col1;
    } cfg_t;

    typedef struct packed {
        op_t         kind;
        logic        addr_ok;
        logic [15:0] addr;
        logic [31:0] load_value;
        logic [15:0] row_start;
        logic [15:0] col_start;
        logic [3:0]  rows;
        logic [3:0]  cols;
        logic [31:0] max_value;
    } qent_t;

    typedef struct packed {
        logic [31:0] position;
        logic [31:0] cell_value;
        logic [31:0] value_slot;
        logic        hit;
    } res_t;

    function automatic logic [SIDE_W-1:0] side_now(input logic [SIDE_W-1:0] leaf_side,
                                                   input logic [SIDE_W-1:0] side_max);
        logic [SIDE_W-1:0] s;
        s = leaf_side;
        if (leaf_side == '0) begin
            s = SIDE_W'(1);
        end else if (leaf_side > side_max) begin
            s = side_max;
        end
        return s;
    endfunction

endpackage

// ----- rtl/dictionary_leaf_window_scan.sv -----
// ----------------------------------------------------------------------------
// dictionary_leaf_window_scan
// Window queries over dictionary-coded raster leaves.
// ----------------------------------------------------------------------------
// Commands enter on the s_ stream and pass through a two-word queue into a
// scan engine, so input is taken while the engine works. A load gives no
// result. A query takes the command, splits the start row and column by
// the leaf side and forms the leaf base; then each row sets up its
// addresses and reads one cell per cycle unless the output stalls, set by
// the single read port of the word store; last the query drains and
// closes. Each result is held back until the next one or the end of the
// query is known so that tlast can mark the last one. Both stores come up
// uninitialized and need no clearing pass; write registers on cfg_ only
// while no query is in flight.
// ----------------------------------------------------------------------------
module dictionary_leaf_window_scan #(
    parameter int LEAF_COUNT    = 4096,
    parameter int WORD_COUNT    = 1024,
    parameter int LEAF_SIDE_MAX = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dlws_pkg::S_TDATA_W-1:0]  s_tdata,   // address, load_value, row_start,
                                                       // col_start, row_end, col_end,
                                                       // max_value
    input  logic [dlws_pkg::S_TUSER_W-1:0]  s_tuser,   // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dlws_pkg::M_TDATA_W-1:0]  m_tdata,   // position, cell_value,
                                                       // value_slot, hit
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dlws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dlws_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dlws_pkg::*;

    cfg_t  cfg_reg;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_valid;
    qent_t q_in;
    qent_t q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_stride <= 17'd1;
            cfg_reg.leaf_side  <= 4'd2;
            cfg_reg.range_low  <= 32'd0;
            cfg_reg.range_high <= 32'hFFFF_FFFF;
            cfg_reg.query_row0 <= 16'd0;
            cfg_reg.query_col0 <= 16'd0;
            cfg_reg.query_col1 <= 16'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ROW_STRIDE: cfg_reg.row_stride <= cfg_data[16:0];
                CFG_LEAF_SIDE:  cfg_reg.leaf_side  <= cfg_data[3:0];
                CFG_RANGE_LOW:  cfg_reg.range_low  <= cfg_data;
                CFG_RANGE_HIGH: cfg_reg.range_high <= cfg_data;
                CFG_QUERY_ROW0: cfg_reg.query_row0 <= cfg_data[15:0];
                CFG_QUERY_COL0: cfg_reg.query_col0 <= cfg_data[15:0];
                CFG_QUERY_COL1: cfg_reg.query_col1 <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    dlws_front #(
        .LEAF_COUNT    (LEAF_COUNT),
        .WORD_COUNT    (WORD_COUNT),
        .LEAF_SIDE_MAX (LEAF_SIDE_MAX)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    dlws_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .dout    (q_out)
    );

    dlws_back #(
        .LEAF_COUNT    (LEAF_COUNT),
        .WORD_COUNT    (WORD_COUNT),
        .LEAF_SIDE_MAX (LEAF_SIDE_MAX)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/dlws_front.sv -----
// ----------------------------------------------------------------------------
// dlws_front
// Input side: unpack the word, classify the mode, clip the window to the
// leaf side and flag out-of-store addresses before queuing the command.
// ----------------------------------------------------------------------------
module dlws_front #(
    parameter int LEAF_COUNT    = 4096,
    parameter int WORD_COUNT    = 1024,
    parameter int LEAF_SIDE_MAX = 8
) (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dlws_pkg::S_TDATA_W-1:0] s_tdata,  // address, load_value, row_start,
                                                     // col_start, row_end, col_end, max_value
    input  logic [dlws_pkg::S_TUSER_W-1:0] s_tuser,  // mode
    input  dlws_pkg::cfg_t                 cfg,
    input  logic                           q_full,
    output logic                           q_push,
    output dlws_pkg::qent_t                q_data
);
    import dlws_pkg::*;

    localparam int LEAF_DEPTH  = (LEAF_COUNT < ADDR_SPACE) ? LEAF_COUNT : ADDR_SPACE;
    localparam int STORE_DEPTH = WORD_COUNT * LEAF_SIDE_MAX * LEAF_SIDE_MAX;
    localparam int WS_DEPTH    = (STORE_DEPTH < ADDR_SPACE) ? STORE_DEPTH : ADDR_SPACE;
    localparam logic [IDX_W-1:0] LEAF_LIM = IDX_W'(LEAF_DEPTH);
    localparam logic [IDX_W-1:0] WS_LIM   = IDX_W'(WS_DEPTH);

    logic [15:0]       addr;
    logic [15:0]       r0;
    logic [15:0]       c0;
    logic [15:0]       r1;
    logic [15:0]       c1;
    logic [SIDE_W-1:0] side;
    logic              known;
    op_t               kind;

    function automatic logic [SIDE_W-1:0] span(input logic [15:0] a, input logic [15:0] b,
                                               input logic [SIDE_W-1:0] sd);
        logic [16:0]       n;
        logic [SIDE_W-1:0] r;
        n = {1'b0, b} - {1'b0, a} + 17'd1;
        r = n[SIDE_W-1:0];
        if (b < a) begin
            r = '0;
        end else if (n > {13'b0, sd}) begin
            r = sd;
        end
        return r;
    endfunction

    assign addr = s_tdata[15:0];
    assign r0   = s_tdata[63:48];
    assign c0   = s_tdata[79:64];
    assign r1   = s_tdata[95:80];
    assign c1   = s_tdata[111:96];
    assign side = side_now(cfg.leaf_side, SIDE_W'(LEAF_SIDE_MAX));

    always_comb begin
        known = 1'b1;
        kind  = OP_READ;
        case (s_tuser)
            MODE_LOAD_CODE: kind = OP_LOAD_CODE;
            MODE_LOAD_WORD: kind = OP_LOAD_WORD;
            MODE_WINDOW:    kind = OP_WINDOW;
            MODE_ANY:       kind = OP_ANY;
            MODE_ALL:       kind = OP_ALL;
            MODE_VALUES:    kind = OP_VALUES;
            MODE_READ:      kind = OP_READ;
            default:        known = 1'b0;
        endcase
    end

    always_comb begin
        q_data.kind       = kind;
        q_data.addr       = addr;
        q_data.load_value = s_tdata[47:16];
        q_data.row_start  = r0;
        q_data.col_start  = c0;
        q_data.max_value  = s_tdata[143:112];
        if (kind == OP_LOAD_WORD) begin
            q_data.addr_ok = ({1'b0, addr} < WS_LIM);
        end else begin
            q_data.addr_ok = ({1'b0, addr} < LEAF_LIM);
        end
        if (kind == OP_READ) begin
            q_data.rows = SIDE_W'(1);
            q_data.cols = SIDE_W'(1);
        end else begin
            q_data.rows = span(r0, r1, side);
            q_data.cols = span(c0, c1, side);
        end
    end

    // drop the unused mode here; it never reaches the back end
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && known;

endmodule

// ----- rtl/dlws_queue.sv -----
// ----------------------------------------------------------------------------
// dlws_queue
// Short command queue between the classifier and the scan engine.
// ----------------------------------------------------------------------------
module dlws_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  dlws_pkg::qent_t din,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output dlws_pkg::qent_t dout
);
    import dlws_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    qent_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign valid = (count_reg != '0);
    assign full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign dout  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/dlws_back.sv -----
// ----------------------------------------------------------------------------
// dlws_back
// Scan engine: owns the leaf-code table and word store, runs loads and walks
// query windows one cell per cycle unless stalled; holds the output register.
// ----------------------------------------------------------------------------
module dlws_back #(
    parameter int LEAF_COUNT    = 4096,
    parameter int WORD_COUNT    = 1024,
    parameter int LEAF_SIDE_MAX = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dlws_pkg::cfg_t                 cfg,
    input  logic                           q_valid,
    input  dlws_pkg::qent_t                q_data,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dlws_pkg::M_TDATA_W-1:0] m_tdata,  // position, cell_value, value_slot, hit
    output logic                           m_tlast
);
    import dlws_pkg::*;

    localparam int LEAF_DEPTH  = (LEAF_COUNT < ADDR_SPACE) ? LEAF_COUNT : ADDR_SPACE;
    localparam int LAW         = (LEAF_DEPTH > 1) ? $clog2(LEAF_DEPTH) : 1;
    localparam int STORE_DEPTH = WORD_COUNT * LEAF_SIDE_MAX * LEAF_SIDE_MAX;
    localparam int WS_DEPTH    = (STORE_DEPTH < ADDR_SPACE) ? STORE_DEPTH : ADDR_SPACE;
    localparam int WAW         = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
    localparam logic [IDX_W-1:0] WS_LIM = IDX_W'(WS_DEPTH);

    logic [CODE_W-1:0] leaf_mem [LEAF_DEPTH];
    logic [31:0]       word_mem [WS_DEPTH];

    bk_state_t         state_reg;
    bk_state_t         state_next;
    qent_t             cmd_reg;
    logic [15:0]       r0sh_reg;
    logic [15:0]       c0sh_reg;
    logic [SIDE_W-1:0] r0m_reg;
    logic [SIDE_W-1:0] c0m_reg;
    logic [1:0]        mcnt_reg;
    logic [CODE_W-1:0] code_rd_reg;
    logic [IDX_W-1:0]  leaf_base_reg;
    logic [16:0]       x_reg;
    logic [SIDE_W-1:0] xm_reg;
    logic [SIDE_W-1:0] rows_left_reg;
    logic [SIDE_W-1:0] cols_left_reg;
    logic [31:0]       pos_prod_reg;
    logic [31:0]       slot_prod_reg;
    logic [31:0]       pos_run_reg;
    logic [31:0]       slot_run_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              b_valid_reg;
    logic              b_oob_reg;
    logic [31:0]       b_pos_reg;
    logic [31:0]       b_slot_reg;
    logic [31:0]       wd_rd_reg;
    logic              any_reg;
    logic              all_reg;
    logic              pend_valid_reg;
    res_t              pend_reg;
    logic              out_valid_reg;
    res_t              out_reg;
    logic              out_last_reg;

    logic [SIDE_W-1:0] side;
    logic [6:0]        sq;
    logic              is_check;
    logic              out_free;
    logic [31:0]       b_v;
    logic              b_ok;
    logic              b_prod;
    logic              b_block;
    logic              b_take;
    logic              issue;
    logic              fin_emit;
    res_t              b_res;
    res_t              fin_res;
    logic [33:0]       pos_mul;
    logic [31:0]       row_off;
    logic [31:0]       width;
    logic [31:0]       slot_mul;
    logic [CODE_W-1:0] code;
    logic [SIDE_W:0]   xm_inc;

    function automatic logic [SIDE_W-1:0] rem_step(input logic [SIDE_W-1:0] rem,
                                                   input logic [3:0] dig,
                                                   input logic [SIDE_W-1:0] sd);
        logic [SIDE_W:0]   t;
        logic [SIDE_W-1:0] r;
        r = rem;
        for (int k = 3; k >= 0; k--) begin
            t = {r, dig[k]};
            if (t >= {1'b0, sd}) begin
                t = t - {1'b0, sd};
            end
            r = t[SIDE_W-1:0];
        end
        return r;
    endfunction

    assign side     = side_now(cfg.leaf_side, SIDE_W'(LEAF_SIDE_MAX));
    assign sq       = 7'({4'b0, side} * {4'b0, side});
    assign is_check = (cmd_reg.kind == OP_ANY) || (cmd_reg.kind == OP_ALL);
    assign out_free = !out_valid_reg || m_tready;

    // evaluate stage
    assign b_v    = cmd_reg.max_value - (b_oob_reg ? 32'd0 : wd_rd_reg);
    assign b_ok   = (b_v >= cfg.range_low) && (b_v <= cfg.range_high);
    assign b_prod = b_valid_reg && ((cmd_reg.kind == OP_WINDOW) ? b_ok : !is_check);
    assign b_block = b_prod && pend_valid_reg && !out_free;
    assign b_take  = b_valid_reg && !b_block;
    assign issue   = (state_reg == BK_SCAN) && !b_block;

    always_comb begin
        b_res            = '0;
        b_res.position   = (cmd_reg.kind == OP_WINDOW) ? b_pos_reg : 32'd0;
        b_res.value_slot = (cmd_reg.kind == OP_VALUES) ? b_slot_reg : 32'd0;
        b_res.cell_value = ((cmd_reg.kind == OP_VALUES) || (cmd_reg.kind == OP_READ))
                           ? b_v : 32'd0;
        fin_res          = pend_reg;
        if (is_check) begin
            fin_res     = '0;
            fin_res.hit = (cmd_reg.kind == OP_ANY) ? any_reg : all_reg;
        end
    end

    // per-row products
    assign pos_mul  = {17'b0, x_reg} * {17'b0, cfg.row_stride};
    assign row_off  = {15'b0, x_reg} - {16'b0, cfg.query_row0};
    assign width    = {16'b0, cfg.query_col1} - {16'b0, cfg.query_col0} + 32'd1;
    assign slot_mul = row_off * width;
    assign code     = cmd_reg.addr_ok ? code_rd_reg : '0;
    assign xm_inc   = {1'b0, xm_reg} + 1'b1;

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        fin_emit   = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if ((q_data.kind == OP_LOAD_CODE) || (q_data.kind == OP_LOAD_WORD)) begin
                        state_next = BK_IDLE;
                    end else if ((q_data.rows == '0) || (q_data.cols == '0)) begin
                        state_next = BK_FINISH;
                    end else begin
                        state_next = BK_PREP;
                    end
                end
            end
            BK_PREP: begin
                if (mcnt_reg == 2'd3) begin
                    state_next = BK_BASE;
                end
            end
            BK_BASE: state_next = BK_ROW;
            BK_ROW:  state_next = BK_RSET;
            BK_RSET: state_next = BK_SCAN;
            BK_SCAN: begin
                if (issue && (cols_left_reg == SIDE_W'(1))) begin
                    state_next = (rows_left_reg == SIDE_W'(1)) ? BK_DRAIN : BK_ROW;
                end
            end
            BK_DRAIN: begin
                if (!b_valid_reg) begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH: begin
                if (!is_check && !pend_valid_reg) begin
                    state_next = BK_IDLE;
                end else if (out_free) begin
                    fin_emit   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // stores
    always_ff @(posedge aclk) begin
        if (q_pop && q_data.addr_ok && (q_data.kind == OP_LOAD_CODE)) begin
            leaf_mem[q_data.addr[LAW-1:0]] <= q_data.load_value[CODE_W-1:0];
        end
        if (state_reg == BK_PREP) begin
            code_rd_reg <= leaf_mem[cmd_reg.addr[LAW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_data.addr_ok && (q_data.kind == OP_LOAD_WORD)) begin
            word_mem[q_data.addr[WAW-1:0]] <= q_data.load_value;
        end
        if (issue) begin
            wd_rd_reg <= word_mem[idx_reg[WAW-1:0]];
        end
    end

    // window walk
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg  <= q_data;
            r0sh_reg <= q_data.row_start;
            c0sh_reg <= q_data.col_start;
            r0m_reg  <= '0;
            c0m_reg  <= '0;
        end
        if (state_reg == BK_PREP) begin
            r0m_reg  <= rem_step(r0m_reg, r0sh_reg[15:12], side);
            c0m_reg  <= rem_step(c0m_reg, c0sh_reg[15:12], side);
            r0sh_reg <= {r0sh_reg[11:0], 4'b0};
            c0sh_reg <= {c0sh_reg[11:0], 4'b0};
        end
        if (state_reg == BK_BASE) begin
            leaf_base_reg <= IDX_W'({7'b0, code} * {10'b0, sq});
            x_reg         <= {1'b0, cmd_reg.row_start};
            xm_reg        <= r0m_reg;
        end
        if (state_reg == BK_ROW) begin
            pos_prod_reg  <= pos_mul[31:0];
            slot_prod_reg <= slot_mul;
        end
        if (state_reg == BK_RSET) begin
            pos_run_reg  <= pos_prod_reg + {16'b0, cmd_reg.col_start};
            slot_run_reg <= slot_prod_reg
                            + ({16'b0, cmd_reg.col_start} - {16'b0, cfg.query_col0});
            idx_reg      <= leaf_base_reg + IDX_W'({13'b0, xm_reg} * {13'b0, side})
                            + {13'b0, c0m_reg};
        end
        if (issue) begin
            b_oob_reg    <= (idx_reg >= WS_LIM);
            b_pos_reg    <= pos_run_reg;
            b_slot_reg   <= slot_run_reg;
            idx_reg      <= idx_reg + 1'b1;
            pos_run_reg  <= pos_run_reg + 32'd1;
            slot_run_reg <= slot_run_reg + 32'd1;
            if (cols_left_reg == SIDE_W'(1)) begin
                x_reg  <= x_reg + 1'b1;
                xm_reg <= (xm_inc == {1'b0, side}) ? '0 : xm_inc[SIDE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcnt_reg      <= '0;
            rows_left_reg <= '0;
            cols_left_reg <= '0;
        end else begin
            if (q_pop) begin
                mcnt_reg <= '0;
            end else if (state_reg == BK_PREP) begin
                mcnt_reg <= mcnt_reg + 1'b1;
            end
            if (state_reg == BK_BASE) begin
                rows_left_reg <= cmd_reg.rows;
            end
            if (state_reg == BK_RSET) begin
                cols_left_reg <= cmd_reg.cols;
            end else if (issue) begin
                cols_left_reg <= cols_left_reg - 1'b1;
                if (cols_left_reg == SIDE_W'(1)) begin
                    rows_left_reg <= rows_left_reg - 1'b1;
                end
            end
        end
    end

    // evaluate, pending and output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg    <= 1'b0;
            any_reg        <= 1'b0;
            all_reg        <= 1'b1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end else begin
            if (issue) begin
                b_valid_reg <= 1'b1;
            end else if (b_take) begin
                b_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                any_reg <= 1'b0;
                all_reg <= 1'b1;
            end else if (b_take && is_check) begin
                if (b_ok) begin
                    any_reg <= 1'b1;
                end else begin
                    all_reg <= 1'b0;
                end
            end
            if (b_take && b_prod) begin
                pend_reg       <= b_res;
                pend_valid_reg <= 1'b1;
            end else if (fin_emit) begin
                pend_valid_reg <= 1'b0;
            end
            if (fin_emit) begin
                out_valid_reg <= 1'b1;
                out_reg       <= fin_res;
                out_last_reg  <= 1'b1;
            end else if (b_take && b_prod && pend_valid_reg) begin
                out_valid_reg <= 1'b1;
                out_reg       <= pend_reg;
                out_last_reg  <= 1'b0;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'b0, out_reg.hit, out_reg.value_slot, out_reg.cell_value,
                       out_reg.position};

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_IDLE) |-> !b_valid_reg)
        else $error("evaluate stage busy while engine idle");

    a_check_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == BK_FINISH) && is_check) |-> !pend_valid_reg)
        else $error("pending result left over at end of check query");

    a_scan_cols: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SCAN) |-> (cols_left_reg != '0))
        else $error("scan with no column left");

    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && (cols_left_reg == SIDE_W'(1)) && (rows_left_reg == SIDE_W'(1)))
        |=> (state_reg == BK_DRAIN))
        else $error("final cell issued without draining");

endmodule

// ----- tb/sv/dictionary_leaf_window_scan_tb.sv -----
// ----------------------------------------------------------------------------
// dictionary_leaf_window_scan_tb
// Self-checking bench for the dictionary leaf window scanner.
// ----------------------------------------------------------------------------
// A queue of command words feeds a clocked driver on the s_ stream. Each
// accepted word runs through a local model of the leaf-code table, the word
// store and the registers, and the results it produces are queued. A clocked
// monitor on the m_ stream compares every result word, field by field, with
// the oldest queued result. Stores are always loaded before a query reads
// them. Registers change only between phases, once the block has drained.
// ----------------------------------------------------------------------------
module dictionary_leaf_window_scan_tb;
    import dlws_pkg::*;

    localparam int LEAF_COUNT     = 4096;
    localparam int WORD_COUNT     = 1024;
    localparam int LEAF_SIDE_MAX  = 8;
    localparam int WORD_SPACE     = WORD_COUNT * LEAF_SIDE_MAX * LEAF_SIDE_MAX;
    localparam int DRAIN_CYCLES   = 300;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int QUIET_LIMIT    = 3000;
    localparam int PHASE_ITEMS    = 68;

    localparam logic [2:0] MODE_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] address;
        logic [31:0] load_value;
        logic [15:0] row_start;
        logic [15:0] col_start;
        logic [15:0] row_end;
        logic [15:0] col_end;
        logic [31:0] max_value;
    } leaf_cmd_t;

    typedef struct packed {
        logic [31:0] position;
        logic [31:0] cell_value;
        logic [31:0] value_slot;
        logic        hit;
        logic        last;
    } leaf_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // model state
    logic [9:0]  leaf_code_mem [0:LEAF_COUNT-1];
    logic [31:0] word_mem      [0:WORD_SPACE-1];
    logic [16:0] cfg_stride = 17'd1;
    logic [3:0]  cfg_side   = 4'd2;
    logic [31:0] cfg_lo     = 32'd0;
    logic [31:0] cfg_hi     = 32'hFFFF_FFFF;
    logic [15:0] cfg_qr0    = 16'd0;
    logic [15:0] cfg_qc0    = 16'd0;
    logic [15:0] cfg_qc1    = 16'd0;

    // what the generator has already queued for loading
    logic [9:0] plan_code [0:LEAF_COUNT-1];
    bit         code_set  [0:LEAF_COUNT-1];
    bit         word_set  [0:WORD_SPACE-1];

    leaf_cmd_t    pending [$];
    leaf_result_t expected_results [$];
    leaf_cmd_t    drv_word;
    leaf_result_t got, want;

    int  send_gap, hold_left, quiet;
    bit  calm, squeeze_armed, squeeze_taken;
    int  errors, words_in, queries_in, results_out, cfg_writes, posted;

    dictionary_leaf_window_scan #(
        .LEAF_COUNT   (LEAF_COUNT),
        .WORD_COUNT   (WORD_COUNT),
        .LEAF_SIDE_MAX(LEAF_SIDE_MAX)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int leaf_dim();
        if (cfg_side == 4'd0) return 1;
        if (cfg_side > 4'(LEAF_SIDE_MAX)) return LEAF_SIDE_MAX;
        return int'(cfg_side);
    endfunction

    function automatic int clip_span(logic [15:0] a, logic [15:0] b, int side);
        int n;
        if (b < a) return 0;
        n = int'(b) - int'(a) + 1;
        return (n > side) ? side : n;
    endfunction

    function automatic longint cell_addr(logic [9:0] code, int side, longint p);
        return longint'(code) * side * side + p;
    endfunction

    function automatic logic [31:0] stored_at(logic [9:0] code, int side, longint p);
        longint idx;
        idx = cell_addr(code, side, p);
        return (idx < WORD_SPACE) ? word_mem[idx] : 32'd0;
    endfunction

    // work out the result words one command word causes
    function automatic void scan_leaf(leaf_cmd_t c);
        leaf_result_t batch [$];
        leaf_result_t r;
        int           side, nr, nc;
        logic [9:0]   code;
        longint       x, y, p;
        logic [31:0]  v, dx, rowslot, width;
        bit           ok, any_ok, all_ok;
        side   = leaf_dim();
        any_ok = 1'b0;
        all_ok = 1'b1;
        code   = (c.address < LEAF_COUNT) ? leaf_code_mem[c.address[11:0]] : 10'd0;
        width  = {16'd0, cfg_qc1} - {16'd0, cfg_qc0} + 32'd1;
        if (c.mode == MODE_LOAD_CODE) begin
            if (c.address < LEAF_COUNT) leaf_code_mem[c.address[11:0]] = c.load_value[9:0];
        end else if (c.mode == MODE_LOAD_WORD) begin
            word_mem[c.address] = c.load_value;
        end else if (c.mode == MODE_READ) begin
            p = (longint'(c.row_start) % side) * side + (longint'(c.col_start) % side);
            r = '0;
            r.cell_value = c.max_value - stored_at(code, side, p);
            batch.push_back(r);
        end else if (c.mode != MODE_UNUSED) begin
            nr = clip_span(c.row_start, c.row_end, side);
            nc = clip_span(c.col_start, c.col_end, side);
            for (int i = 0; i < nr; i++) begin
                x       = longint'(c.row_start) + i;
                p       = (x % side) * side + (longint'(c.col_start) % side);
                dx      = 32'(x - longint'(cfg_qr0));
                rowslot = dx * width;
                for (int j = 0; j < nc; j++) begin
                    y  = longint'(c.col_start) + j;
                    v  = c.max_value - stored_at(code, side, p + j);
                    ok = (v >= cfg_lo) && (v <= cfg_hi);
                    r  = '0;
                    if (c.mode == MODE_WINDOW) begin
                        r.position = 32'(x * longint'(cfg_stride) + y);
                        if (ok) batch.push_back(r);
                    end else if (c.mode == MODE_VALUES) begin
                        r.cell_value = v;
                        r.value_slot = rowslot + 32'(y - longint'(cfg_qc0));
                        batch.push_back(r);
                    end else if (ok) begin
                        any_ok = 1'b1;
                    end else begin
                        all_ok = 1'b0;
                    end
                end
            end
            if (c.mode == MODE_ANY || c.mode == MODE_ALL) begin
                r     = '0;
                r.hit = (c.mode == MODE_ANY) ? any_ok : all_ok;
                batch.push_back(r);
            end
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[k]) expected_results.push_back(batch[k]);
    endfunction

    function automatic leaf_cmd_t make(logic [2:0] mode, logic [15:0] address,
                                       logic [31:0] load_value, logic [15:0] row_start,
                                       logic [15:0] col_start, logic [15:0] row_end,
                                       logic [15:0] col_end, logic [31:0] max_value);
        leaf_cmd_t c;
        c.mode       = mode;
        c.address    = address;
        c.load_value = load_value;
        c.row_start  = row_start;
        c.col_start  = col_start;
        c.row_end    = row_end;
        c.col_end    = col_end;
        c.max_value  = max_value;
        return c;
    endfunction

    function automatic logic [31:0] pick_word(int lo, int hi);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 32'd0;
        if (r == 1) return 32'hFFFF_FFFF;
        if (r < 4) return $urandom;
        return 32'($urandom_range(lo, hi));
    endfunction

    function automatic logic [9:0] pick_code();
        int r;
        r = $urandom_range(0, 19);
        if (r < 5) return 10'd0;
        if (r < 10) return 10'd1;
        if (r < 15) return 10'd3;
        if (r < 19) return 10'h3FF;
        return 10'($urandom);
    endfunction

    function automatic logic [15:0] pick_leaf();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 16'($urandom_range(0, 7));
        if (r == 7) return 16'(LEAF_COUNT - 1);
        if (r == 8) return 16'($urandom_range(LEAF_COUNT, 65535));
        return 16'($urandom_range(0, LEAF_COUNT - 1));
    endfunction

    function automatic logic [15:0] window_start();
        return ($urandom_range(0, 4) < 3) ? 16'($urandom_range(0, 15)) : 16'($urandom);
    endfunction

    function automatic logic [15:0] window_end(logic [15:0] s);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return s - 16'($urandom_range(1, 2));
        if (r == 1) return 16'($urandom);
        return s + 16'($urandom_range(0, 8));
    endfunction

    function automatic void post(leaf_cmd_t c);
        if (c.mode == MODE_LOAD_CODE && c.address < LEAF_COUNT) begin
            plan_code[c.address[11:0]] = c.load_value[9:0];
            code_set[c.address[11:0]]  = 1'b1;
        end
        if (c.mode == MODE_LOAD_WORD) word_set[c.address] = 1'b1;
        pending.push_back(c);
        posted++;
    endfunction

    // load whatever a query would read that was never written, then queue it
    function automatic void issue(leaf_cmd_t c);
        int         side, nr, nc;
        logic [9:0] code;
        longint     x, idx;
        side = leaf_dim();
        if (c.mode >= MODE_WINDOW && c.mode <= MODE_READ) begin
            if (c.address < LEAF_COUNT && !code_set[c.address[11:0]])
                post(make(MODE_LOAD_CODE, c.address, {22'($urandom), pick_code()},
                          16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          $urandom));
            code = (c.address < LEAF_COUNT) ? plan_code[c.address[11:0]] : 10'd0;
            nr = (c.mode == MODE_READ) ? 1 : clip_span(c.row_start, c.row_end, side);
            nc = (c.mode == MODE_READ) ? 1 : clip_span(c.col_start, c.col_end, side);
            for (int i = 0; i < nr; i++) begin
                x = longint'(c.row_start) + i;
                for (int j = 0; j < nc; j++) begin
                    idx = cell_addr(code, side,
                                    (x % side) * side + (longint'(c.col_start) % side) + j);
                    if (idx < WORD_SPACE && !word_set[idx])
                        post(make(MODE_LOAD_WORD, 16'(idx), pick_word(0, 20), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom), $urandom));
                end
            end
        end
        post(c);
    endfunction

    function automatic leaf_cmd_t random_item();
        leaf_cmd_t   c;
        int          r;
        logic [15:0] r0, c0;
        r  = $urandom_range(0, 99);
        r0 = window_start();
        c0 = window_start();
        c  = make(MODE_READ, pick_leaf(), $urandom, r0, c0, window_end(r0), window_end(c0),
                  pick_word(10, 30));
        if (r < 8) begin
            c.mode       = MODE_LOAD_WORD;
            c.address    = 16'($urandom);
            c.load_value = pick_word(0, 20);
        end else if (r < 14) begin
            c.mode       = MODE_LOAD_CODE;
            c.load_value = {22'($urandom), pick_code()};
        end else if (r < 30) begin
            c.mode = MODE_WINDOW;
        end else if (r < 42) begin
            c.mode = MODE_ANY;
        end else if (r < 54) begin
            c.mode = MODE_ALL;
        end else if (r < 72) begin
            c.mode = MODE_VALUES;
        end else if (r >= 97) begin
            c.mode = MODE_UNUSED;
        end
        return c;
    endfunction

    // queue random words, the loads they pull in included, up to the quota
    task automatic run_random(int quota);
        int        stop;
        leaf_cmd_t c;
        stop = posted + quota;
        while (posted < stop) begin
            c = random_item();
            issue(c);
        end
    endtask

    function automatic int idle_len(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_ROW_STRIDE: cfg_stride = val[16:0];
            CFG_LEAF_SIDE:  cfg_side   = val[3:0];
            CFG_RANGE_LOW:  cfg_lo     = val;
            CFG_RANGE_HIGH: cfg_hi     = val;
            CFG_QUERY_ROW0: cfg_qr0    = val[15:0];
            CFG_QUERY_COL0: cfg_qc0    = val[15:0];
            CFG_QUERY_COL1: cfg_qc1    = val[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [16:0] stride, logic [3:0] side, logic [31:0] lo,
                                 logic [31:0] hi, logic [15:0] qr0, logic [15:0] qc0,
                                 logic [15:0] qc1);
        write_reg(CFG_ROW_STRIDE, {15'd0, stride});
        write_reg(CFG_LEAF_SIDE, {28'd0, side});
        write_reg(CFG_RANGE_LOW, lo);
        write_reg(CFG_RANGE_HIGH, hi);
        write_reg(CFG_QUERY_ROW0, {16'd0, qr0});
        write_reg(CFG_QUERY_COL0, {16'd0, qc0});
        write_reg(CFG_QUERY_COL1, {16'd0, qc1});
    endtask

    // hold until every word is taken and answered, then let loads finish
    task automatic settle();
        while (pending.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                scan_leaf(drv_word);
                words_in++;
                if (drv_word.mode >= MODE_WINDOW && drv_word.mode <= MODE_READ) queries_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() > 0) begin
                    drv_word = pending.pop_front();
                    s_tuser  <= drv_word.mode;
                    s_tdata  <= {drv_word.max_value, drv_word.col_end, drv_word.row_end,
                                 drv_word.col_start, drv_word.row_start,
                                 drv_word.load_value, drv_word.address};
                    s_tvalid <= 1'b1;
                    send_gap = idle_len(calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_out++;
                got.position   = m_tdata[31:0];
                got.cell_value = m_tdata[63:32];
                got.value_slot = m_tdata[95:64];
                got.hit        = m_tdata[96];
                got.last       = m_tlast;
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: %h last %b", m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("position", want.position, got.position);
                    check_field("cell_value", want.cell_value, got.cell_value);
                    check_field("value_slot", want.value_slot, got.value_slot);
                    check_field("hit", 32'(want.hit), 32'(got.hit));
                    check_field("last", 32'(want.last), 32'(got.last));
                end
            end
            if (squeeze_armed && !squeeze_taken) begin
                squeeze_taken = 1'b1;
                hold_left     = SQUEEZE_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) hold_left = idle_len(1'b0);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values, every mode and the corner cases
        issue(make(MODE_LOAD_CODE, 16'd0, 32'hFFFF_FC01, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 32'hFFFF_FFFF));
        issue(make(MODE_LOAD_CODE, 16'(LEAF_COUNT - 1), 32'h0000_03FF, 0, 0, 0, 0, 0));
        issue(make(MODE_LOAD_CODE, 16'(LEAF_COUNT), 32'd5, 0, 0, 0, 0, 0));
        issue(make(MODE_LOAD_CODE, 16'hFFFF, 32'd2, 0, 0, 0, 0, 0));
        issue(make(MODE_LOAD_WORD, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        issue(make(MODE_LOAD_WORD, 16'd0, 32'd0, 0, 0, 0, 0, 0));
        issue(make(MODE_READ, 16'd0, 0, 0, 0, 0, 0, 32'd0));
        issue(make(MODE_READ, 16'd0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   32'hFFFF_FFFF));
        issue(make(MODE_READ, 16'h1000, 0, 1, 0, 1, 0, 32'h10));
        issue(make(MODE_READ, 16'(LEAF_COUNT - 1), 0, 1, 1, 1, 1, 32'h8000_0000));
        issue(make(MODE_WINDOW, 16'd0, 0, 0, 0, 1, 1, 32'hFFFF_FFFF));
        issue(make(MODE_WINDOW, 16'd0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd5));
        issue(make(MODE_WINDOW, 16'd1, 0, 5, 3, 4, 9, 32'd0));
        issue(make(MODE_WINDOW, 16'd0, 0, 1, 1, 5, 2, 32'd7));
        issue(make(MODE_ANY, 16'd0, 0, 3, 0, 2, 1, 32'd0));
        issue(make(MODE_ALL, 16'd0, 0, 3, 0, 2, 1, 32'd0));
        issue(make(MODE_ANY, 16'd0, 0, 0, 0, 1, 1, 32'h8000_0000));
        issue(make(MODE_ALL, 16'(LEAF_COUNT - 1), 0, 0, 0, 1, 1, 32'hFFFF_FFFF));
        issue(make(MODE_VALUES, 16'd0, 0, 0, 0, 1, 1, 32'h1234_5678));
        issue(make(MODE_VALUES, 16'hFFFF, 0, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF, 32'd0));
        issue(make(MODE_VALUES, 16'd2, 0, 4, 4, 3, 9, 32'd1));
        issue(make(MODE_VALUES, 16'd3, 0, 0, 0, 16'hFFFF, 16'hFFFF, 32'd9));
        issue(make(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 32'hFFFF_FFFF));
        settle();

        // full leaf side; hold the output back while input keeps coming
        apply_setting(17'h1FFFF, 4'd8, 32'd5, 32'd20, 16'd0, 16'd0, 16'd7);
        calm          = 1'b1;
        squeeze_armed = 1'b1;
        issue(make(MODE_VALUES, 16'(LEAF_COUNT - 1), 0, 7, 7, 14, 14, 32'd12));
        issue(make(MODE_WINDOW, 16'(LEAF_COUNT - 1), 0, 7, 7, 14, 14, 32'd12));
        run_random(PHASE_ITEMS);
        settle();
        calm = 1'b0;

        apply_setting(17'd65536, 4'd15, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        run_random(PHASE_ITEMS);
        settle();

        apply_setting(17'd0, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd3, 16'd2, 16'hFFFF);
        run_random(PHASE_ITEMS);
        settle();

        apply_setting(17'd100, 4'd3, 32'd10, 32'd5, 16'd1, 16'd1, 16'd4);
        run_random(PHASE_ITEMS);
        settle();

        apply_setting(17'd2, 4'd4, 32'd0, 32'd15, 16'd0, 16'd3, 16'd3);
        run_random(PHASE_ITEMS);
        settle();

        apply_setting(17'($urandom), 4'($urandom_range(1, 8)), 32'($urandom_range(0, 10)),
                      32'($urandom_range(11, 30)), 16'($urandom_range(0, 7)),
                      16'($urandom_range(0, 7)), 16'($urandom_range(7, 14)));
        run_random(PHASE_ITEMS);
        settle();

        $display("Checked %0d input words (%0d queries) against %0d result words",
                 words_in, queries_in, results_out);
        $display("over %0d register writes in seven settings, with one long output stall",
                 cfg_writes);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dlws_pkg.sv
rtl/dlws_front.sv
rtl/dlws_queue.sv
rtl/dlws_back.sv
rtl/dictionary_leaf_window_scan.sv
tb/sv/dictionary_leaf_window_scan_tb.sv
